// ===== src/base64_decoder_top_macros.svh =====
// Assertion macros for the base64 decoder
`ifndef BASE64_DECODER_TOP_MACROS_SVH
`define BASE64_DECODER_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define B64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds, reset included
`define B64_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) !(cond)) else $error(msg);

`endif

// ===== src/b64dec_pkg.sv =====
// Shared types, constants and the alphabet lookup of the base64 decoder
package b64dec_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BAD    = 2'd1;
  localparam logic [1:0] STATUS_LENGTH = 2'd2;

  localparam int unsigned RES_DEPTH = 4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_status;
    logic [1:0]  status;
    logic [15:0] error_position;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [2:0]        count;
    result_t [3:0]     res;
  } load_t;

  // returns {found, sextet}
  function automatic logic [6:0] sextet(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r = {1'b1, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
    end else if (ch == PLUS_CHAR) begin
      r = {1'b1, 6'd62};
    end else if (ch == SLASH_CHAR) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ===== src/base64_decoder_top.sv =====
// Base64 decoder top level: one character in per item, decoded bytes and a status out
// Takes one character per cycle unless the input is stalled; each result passes through the
// result register before it leaves. A character that completes a quartet or ends a message is
// held back until the four-entry result register is empty or hands out its last item in that
// cycle. The register drains one item per cycle while the output is not stalled, so the results
// of a quartet (at most four with the status) are gone by the time the next quartet completes,
// and streams of whole quartets run at one character per cycle. A message end that comes while
// the results of the last load are still being handed out stalls the input, and output stalls
// lengthen it. Each message ends with a status item (ok, bad character with its index, or bad
// length); bytes of a message that ends in error are to be dropped downstream.
// Character indexes saturate at the smaller of 65535 and MAX_MESSAGE_LENGTH - 1.
`include "base64_decoder_top_macros.svh"

module base64_decoder_top #(
  parameter longint unsigned MAX_MESSAGE_LENGTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  symbol_i,
  input  logic        last_symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic        is_status_o,
  output logic [1:0]  status_o,
  output logic [15:0] error_position_o,
  output logic        last_result_o
);

  localparam longint unsigned CapWide =
    (MAX_MESSAGE_LENGTH - 1 < 64'd65535) ? (MAX_MESSAGE_LENGTH - 1) : 64'd65535;
  localparam logic [15:0] PosCap = CapWide[15:0];

  logic                gen, buf_ready, accept, buf_load;
  logic                data_clean, status_take;
  b64dec_pkg::load_t   load;
  b64dec_pkg::result_t res;

  assign in_stall_o = gen && !buf_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign buf_load   = load.valid && (load.count != 3'd0);

  b64dec_unit #(
    .PosCap(PosCap)
  ) u_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .gen_o        (gen),
    .load_o       (load)
  );

  b64dec_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .ready_o    (buf_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign data_byte_o      = res.data_byte;
  assign is_status_o      = res.is_status;
  assign status_o         = res.status;
  assign error_position_o = res.error_position;
  assign last_result_o    = res.last_result;

  assign data_clean  = (status_o == b64dec_pkg::STATUS_OK) && (error_position_o == 16'd0) &&
                       !last_result_o;
  assign status_take = out_valid_o && !out_stall_i && last_result_o;

  `B64_ASSERT(a_last_is_status, out_valid_o && last_result_o |-> is_status_o, "last without status")
  `B64_ASSERT(a_data_clean, out_valid_o && !is_status_o |-> data_clean, "data item with status")
  `B64_ASSERT(a_drain_after_status, status_take |=> !out_valid_o || $past(buf_load), "stray item")
  `B64_NEVER(a_no_bad_code, out_valid_o && status_o > b64dec_pkg::STATUS_LENGTH, "bad status code")

endmodule

// ===== src/b64dec_unit.sv =====
// Quartet gathering, alphabet lookup and result generation
module b64dec_unit #(
  parameter logic [15:0] PosCap = 16'hFFFF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        symbol_i,
  input  logic              last_symbol_i,
  output logic              gen_o,
  output b64dec_pkg::load_t load_o
);

  logic [7:0]  held_q [3];
  logic [7:0]  held_d [3];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [15:0] cc_q, cc_d;
  logic        err_q, err_d;
  logic [15:0] eidx_q, eidx_d;

  logic [6:0]  sx0, sx1, sx2, sx3;
  logic        full, pad2, pad3;
  logic [1:0]  n_dec, dec_off, n_out;
  logic        dec_err, err_new;
  logic [15:0] eidx_new;
  logic [7:0]  b0, b1, b2;
  b64dec_pkg::result_t stat;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [2:0] b);
    logic [16:0] s;
    s = {1'b0, a} + 17'(b);
    return (s > {1'b0, PosCap}) ? PosCap : s[15:0];
  endfunction

  assign full  = (held_cnt_q == 2'd3);
  assign gen_o = full || last_symbol_i;

  assign sx0  = b64dec_pkg::sextet(held_q[0]);
  assign sx1  = b64dec_pkg::sextet(held_q[1]);
  assign sx2  = b64dec_pkg::sextet(held_q[2]);
  assign sx3  = b64dec_pkg::sextet(symbol_i);
  assign pad2 = last_symbol_i && (held_q[2] == b64dec_pkg::PAD_CHAR);
  assign pad3 = last_symbol_i && (symbol_i == b64dec_pkg::PAD_CHAR);

  assign b0 = {sx0[5:0], sx1[5:4]};
  assign b1 = {sx1[3:0], sx2[5:2]};
  assign b2 = {sx2[1:0], sx3[5:0]};

  always_comb begin
    n_dec   = 2'd0;
    dec_err = 1'b0;
    dec_off = 2'd0;
    if (!sx0[6]) begin
      dec_err = 1'b1;
      dec_off = 2'd0;
    end else if (!sx1[6]) begin
      dec_err = 1'b1;
      dec_off = 2'd1;
    end else if (pad2) begin
      n_dec = 2'd1;
    end else if (!sx2[6]) begin
      n_dec   = 2'd1;
      dec_err = 1'b1;
      dec_off = 2'd2;
    end else if (pad3) begin
      n_dec = 2'd2;
    end else if (!sx3[6]) begin
      n_dec   = 2'd2;
      dec_err = 1'b1;
      dec_off = 2'd3;
    end else begin
      n_dec = 2'd3;
    end
  end

  assign err_new  = err_q || dec_err;
  assign eidx_new = (!err_q && dec_err) ? sat_add(cc_q, {1'b0, dec_off}) : eidx_q;
  assign n_out    = err_q ? 2'd0 : n_dec;

  always_comb begin
    stat                = '0;
    stat.is_status      = 1'b1;
    stat.last_result    = 1'b1;
    load_o              = '0;
    load_o.valid        = accept_i && gen_o;
    if (full) begin
      load_o.res[0].data_byte = b0;
      load_o.res[1].data_byte = b1;
      load_o.res[2].data_byte = b2;
      load_o.count            = {1'b0, n_out} + 3'(last_symbol_i);
      if (last_symbol_i) begin
        stat.status         = err_new ? b64dec_pkg::STATUS_BAD : b64dec_pkg::STATUS_OK;
        stat.error_position = err_new ? eidx_new : 16'd0;
        load_o.res[n_out]   = stat;
      end
    end else begin
      stat.status   = b64dec_pkg::STATUS_LENGTH;
      load_o.res[0] = stat;
      load_o.count  = 3'd1;
    end
  end

  always_comb begin
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    cc_d       = cc_q;
    err_d      = err_q;
    eidx_d     = eidx_q;
    if (accept_i) begin
      if (full || last_symbol_i) begin
        held_d     = '{default: 8'd0};
        held_cnt_d = 2'd0;
        if (last_symbol_i) begin
          cc_d   = 16'd0;
          err_d  = 1'b0;
          eidx_d = 16'd0;
        end else begin
          cc_d   = sat_add(cc_q, 3'd4);
          err_d  = err_new;
          eidx_d = eidx_new;
        end
      end else begin
        held_d[held_cnt_q] = symbol_i;
        held_cnt_d         = held_cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '{default: 8'd0};
      held_cnt_q <= 2'd0;
      cc_q       <= 16'd0;
      err_q      <= 1'b0;
      eidx_q     <= 16'd0;
    end else begin
      held_q     <= held_d;
      held_cnt_q <= held_cnt_d;
      cc_q       <= cc_d;
      err_q      <= err_d;
      eidx_q     <= eidx_d;
    end
  end

endmodule

// ===== src/b64dec_outbuf.sv =====
// Four-entry result register that hands out one item per cycle unless the output stalls
module b64dec_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64dec_pkg::load_t   load_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64dec_pkg::result_t res_o
);

  b64dec_pkg::result_t res_q [b64dec_pkg::RES_DEPTH];
  b64dec_pkg::result_t res_d [b64dec_pkg::RES_DEPTH];
  logic [2:0] cnt_q, cnt_d;
  logic       take;

  assign out_valid_o = (cnt_q != 3'd0);
  assign take        = out_valid_o && !out_stall_i;
  assign ready_o     = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && take);
  assign res_o       = res_q[0];

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (load_i.valid) begin
      for (int i = 0; i < b64dec_pkg::RES_DEPTH; i++) begin
        res_d[i] = load_i.res[i];
      end
      cnt_d = load_i.count;
    end else if (take) begin
      for (int i = 0; i < b64dec_pkg::RES_DEPTH - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
